>>> sv/fat_cluster_chain_allocator_macros.svh
// Assertion macros for the FAT32 cluster chain allocator.
// Used by the RTL files that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_MACROS_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held
`define FCCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held
`define FCCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCCA_ASSERT_IMP(lbl, ante, cons, msg)
`define FCCA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/fcca_pkg.sv
// Shared types and constants of the FAT32 cluster chain allocator.
// No dependencies; used by fcca_table and fat_cluster_chain_allocator.
package fcca_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 28;
    localparam int CNT_W       = 13;

    localparam logic [ENTRY_W-1:0] END_MARK = 28'hFFFFFF8;

    // Operation codes of the func field
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_WALK  = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_TAIL  = 6'b000100,
        S_FETCH = 6'b001000,
        S_EXAM  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    // Write request into the table memory
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } t_wr_req;

endpackage

>>> sv/fcca_table.sv
// Allocation table storage: one write port, one read port with registered data.
// Depends on fcca_pkg for depth, widths and the write request struct.
module fcca_table (
    input  logic                        i_clk,
    input  fcca_pkg::t_wr_req           i_wr,
    input  logic [fcca_pkg::IDX_W-1:0]  i_raddr,
    output logic [fcca_pkg::ENTRY_W-1:0] o_rdata
);

    logic [fcca_pkg::ENTRY_W-1:0] r_mem [fcca_pkg::TABLE_DEPTH];
    logic [fcca_pkg::ENTRY_W-1:0] r_rdata;

    // Write one entry when requested
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read every cycle, data registered and valid in the next cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fat_cluster_chain_allocator.sv
// FAT32 cluster chain allocator: top level with the operation sequencer.
// Depends on fcca_pkg, fcca_table and fat_cluster_chain_allocator_macros.svh.
//
// Usage:
//   Request channel (i_valid/o_ready) carries func, index, value, count; one
//   transaction yields exactly one result on the response channel
//   (o_valid/i_ready) with cluster, linked and error.
//   Config channel (i_cfg_valid/o_cfg_ready, always ready) writes table_size;
//   write it only while no request is in flight.
//   Sequencer states per request, in order:
//     write entry, or an out-of-range index on write, walk or read: done.
//     read entry: fetch, exam, done.
//     allocate: scan over table_size entries (one entry a cycle, stops early
//       once count clusters are linked), then tail and done.
//     find last: fetch and exam per hop, up to table_size hops, then done.
//   One request at a time; o_ready is high only while the sequencer idles.
//   Reset clears the sequencer and sets table_size to 4096; the table itself
//   holds garbage until software writes each entry. No clearing pass.
//   A stalled receiver holds the result in the output register; the sequencer
//   then waits in its done state until the result is taken.
`include "fat_cluster_chain_allocator_macros.svh"

module fat_cluster_chain_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [11:0]                   i_index,
    input  logic [27:0]                   i_value,
    input  logic [12:0]                   i_count,
    // response channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [27:0]                   o_cluster,
    output logic [12:0]                   o_linked,
    output logic                          o_error,
    // config channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [12:0]                   i_cfg_data
);

    localparam int IDX_W   = fcca_pkg::IDX_W;
    localparam int ENTRY_W = fcca_pkg::ENTRY_W;
    localparam int CNT_W   = fcca_pkg::CNT_W;

    fcca_pkg::t_state r_state, n_state;
    fcca_pkg::t_func  r_func, n_func;

    logic [CNT_W-1:0]   r_table_size;
    logic [CNT_W-1:0]   r_cur, n_cur;
    logic               r_chk_v, n_chk_v;
    logic [IDX_W-1:0]   r_chk_addr, n_chk_addr;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_hops, n_hops;
    logic [ENTRY_W-1:0] r_res_cluster, n_res_cluster;
    logic [CNT_W-1:0]   r_res_linked, n_res_linked;
    logic               r_res_error, n_res_error;
    logic               r_out_valid, n_out_valid;
    logic [ENTRY_W-1:0] r_out_cluster, n_out_cluster;
    logic [CNT_W-1:0]   r_out_linked, n_out_linked;
    logic               r_out_error, n_out_error;

    logic [CNT_W-1:0]   w_eff_size;
    logic               w_idx_ok;
    logic               w_accept;
    logic               w_issue;
    logic               w_hit;
    logic [ENTRY_W-1:0] w_rdata;
    fcca_pkg::t_wr_req  w_wr;

    // Cap the table size at the storage depth
    assign w_eff_size = (r_table_size > CNT_W'(fcca_pkg::TABLE_DEPTH))
                        ? CNT_W'(fcca_pkg::TABLE_DEPTH) : r_table_size;
    assign w_idx_ok   = {1'b0, i_index} < w_eff_size;
    assign o_ready    = (r_state == fcca_pkg::S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Scan side: issue one read per cycle, check the data of the previous one
    assign w_issue = r_cur < w_eff_size;
    assign w_hit   = r_chk_v && (r_n < r_cnt) && (w_rdata == '0);

    fcca_table u_table (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (r_cur[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_cur         = r_cur;
        n_chk_v       = r_chk_v;
        n_chk_addr    = r_chk_addr;
        n_prev        = r_prev;
        n_n           = r_n;
        n_cnt         = r_cnt;
        n_hops        = r_hops;
        n_res_cluster = r_res_cluster;
        n_res_linked  = r_res_linked;
        n_res_error   = r_res_error;
        n_out_valid   = r_out_valid;
        n_out_cluster = r_out_cluster;
        n_out_linked  = r_out_linked;
        n_out_error   = r_out_error;
        w_wr.we       = 1'b0;
        w_wr.addr     = r_prev;
        w_wr.data     = ENTRY_W'(r_chk_addr);

        // Drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            fcca_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_func        = fcca_pkg::t_func'(i_func);
                    n_res_cluster = '0;
                    n_res_linked  = '0;
                    n_res_error   = 1'b0;
                    n_cur         = {1'b0, i_index};
                    n_hops        = '0;
                    case (fcca_pkg::t_func'(i_func))
                        fcca_pkg::FUNC_WRITE: begin
                            w_wr.we     = w_idx_ok;
                            w_wr.addr   = i_index;
                            w_wr.data   = i_value;
                            n_res_error = !w_idx_ok;
                            n_state     = fcca_pkg::S_DONE;
                        end
                        fcca_pkg::FUNC_ALLOC: begin
                            n_cur   = '0;
                            n_chk_v = 1'b0;
                            n_n     = '0;
                            n_cnt   = i_count;
                            n_state = fcca_pkg::S_SCAN;
                        end
                        default: begin
                            // walk or read: range check first
                            n_res_error = !w_idx_ok;
                            n_state     = w_idx_ok ? fcca_pkg::S_FETCH : fcca_pkg::S_DONE;
                        end
                    endcase
                end
            end
            fcca_pkg::S_SCAN: begin
                if ((r_n == r_cnt) || (!r_chk_v && !w_issue)) begin
                    n_state = fcca_pkg::S_TAIL;
                end else begin
                    n_chk_v    = w_issue;
                    n_chk_addr = r_cur[IDX_W-1:0];
                    if (w_issue) begin
                        n_cur = r_cur + 1'b1;
                    end
                    // Link the free entry behind the previous one
                    if (w_hit) begin
                        if (r_n == '0) begin
                            n_res_cluster = ENTRY_W'(r_chk_addr);
                        end else begin
                            w_wr.we   = 1'b1;
                            w_wr.addr = r_prev;
                            w_wr.data = ENTRY_W'(r_chk_addr);
                        end
                        n_prev = r_chk_addr;
                        n_n    = r_n + 1'b1;
                    end
                end
            end
            fcca_pkg::S_TAIL: begin
                // Mark the tail end-of-chain
                w_wr.we      = (r_n != '0);
                w_wr.addr    = r_prev;
                w_wr.data    = fcca_pkg::END_MARK;
                n_res_linked = r_n;
                n_state      = fcca_pkg::S_DONE;
            end
            fcca_pkg::S_FETCH: begin
                n_state = fcca_pkg::S_EXAM;
            end
            fcca_pkg::S_EXAM: begin
                n_state = fcca_pkg::S_DONE;
                if (r_func == fcca_pkg::FUNC_READ) begin
                    n_res_cluster = w_rdata;
                end else if (w_rdata >= fcca_pkg::END_MARK) begin
                    n_res_cluster = ENTRY_W'(r_cur);
                end else if ((r_hops >= w_eff_size) || (w_rdata >= ENTRY_W'(w_eff_size))) begin
                    n_res_error = 1'b1;
                end else begin
                    // Follow the link
                    n_cur   = w_rdata[CNT_W-1:0];
                    n_hops  = r_hops + 1'b1;
                    n_state = fcca_pkg::S_FETCH;
                end
            end
            fcca_pkg::S_DONE: begin
                // Hand over once the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_cluster = r_res_cluster;
                    n_out_linked  = r_res_linked;
                    n_out_error   = r_res_error;
                    n_state       = fcca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcca_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fcca_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_chk_v      <= 1'b0;
            r_table_size <= CNT_W'(4096);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chk_v     <= n_chk_v;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_cur         <= n_cur;
        r_chk_addr    <= n_chk_addr;
        r_prev        <= n_prev;
        r_n           <= n_n;
        r_cnt         <= n_cnt;
        r_hops        <= n_hops;
        r_res_cluster <= n_res_cluster;
        r_res_linked  <= n_res_linked;
        r_res_error   <= n_res_error;
        r_out_cluster <= n_out_cluster;
        r_out_linked  <= n_out_linked;
        r_out_error   <= n_out_error;
    end

    assign o_valid   = r_out_valid;
    assign o_cluster = r_out_cluster;
    assign o_linked  = r_out_linked;
    assign o_error   = r_out_error;

    // Checks
    `FCCA_ASSERT_NXT(a_busy_after_accept, w_accept, r_state != fcca_pkg::S_IDLE, "idle after accept")
    `FCCA_ASSERT_IMP(a_linked_le_count, r_state == fcca_pkg::S_SCAN, r_n <= r_cnt, "linked over count")
    `FCCA_ASSERT_IMP(a_write_states, w_wr.we, (r_state == fcca_pkg::S_IDLE) || (r_state == fcca_pkg::S_SCAN) || (r_state == fcca_pkg::S_TAIL), "table write out of sequence")
    `FCCA_ASSERT_IMP(a_err_no_link, o_valid && o_error, o_linked == '0, "error with linked clusters")

endmodule

>>> tb/sv/fat_chain_checker.sv
`timescale 1ns / 1ps
// Response checker for the FAT32 cluster chain allocator: keeps its own copy of the
// allocation table and of table_size, predicts one answer per request and compares it.
// Depends on fcca_pkg.
module fat_chain_checker
    import fcca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel as seen at the block
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [1:0]         i_func,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [ENTRY_W-1:0] i_value,
    input  logic [CNT_W-1:0]   i_count,
    // response channel as seen at the block
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [ENTRY_W-1:0] i_cluster,
    input  logic [CNT_W-1:0]   i_linked,
    input  logic               i_error,
    // table_size write channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_cnt
);

    typedef struct packed {
        logic [ENTRY_W-1:0] cluster;
        logic [CNT_W-1:0]   linked;
        logic               error;
    } t_answer;

    logic [ENTRY_W-1:0] fat_copy [TABLE_DEPTH];
    logic [CNT_W-1:0]   size_cfg;
    t_answer            answer_q [$];
    int                 fail_total = 0;

    assign o_fail_cnt = fail_total;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] due);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, seen, due);
        fail_total++;
    endtask

    // Apply one operation to the table copy and return the answer it gives
    function automatic t_answer apply_fat_op(input t_func op, input logic [IDX_W-1:0] idx,
                                             input logic [ENTRY_W-1:0] val,
                                             input logic [CNT_W-1:0] cnt);
        t_answer            ans;
        int                 span;
        int                 c;
        int                 prev;
        int                 n;
        int                 cur;
        int                 hops;
        logic [ENTRY_W-1:0] link;
        logic               stop;
        ans  = '0;
        span = (size_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_cfg);
        case (op)
            FUNC_WRITE: begin
                if (idx < span)
                    fat_copy[idx] = val;
                else
                    ans.error = 1'b1;
            end
            FUNC_ALLOC: begin
                // first fit: link free entries in index order, tail gets the end mark
                prev = 0;
                n    = 0;
                for (c = 0; c < span && n < cnt; c++) begin
                    if (fat_copy[c] == '0) begin
                        if (n == 0)
                            ans.cluster = ENTRY_W'(c);
                        else
                            fat_copy[prev] = ENTRY_W'(c);
                        fat_copy[c] = END_MARK;
                        prev = c;
                        n++;
                    end
                end
                ans.linked = CNT_W'(n);
            end
            FUNC_WALK: begin
                if (idx >= span) begin
                    ans.error = 1'b1;
                end else begin
                    cur  = idx;
                    hops = 0;
                    stop = 1'b0;
                    while (!stop) begin
                        link = fat_copy[cur];
                        if (link >= END_MARK) begin
                            ans.cluster = ENTRY_W'(cur);
                            stop = 1'b1;
                        end else if (hops >= span || link >= span) begin
                            // broken link or a loop: give up
                            ans.error = 1'b1;
                            stop = 1'b1;
                        end else begin
                            cur = link;
                            hops++;
                        end
                    end
                end
            end
            FUNC_READ: begin
                if (idx < span)
                    ans.cluster = fat_copy[idx];
                else
                    ans.error = 1'b1;
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Track config, predict on each request transaction, check each response transaction
    always @(posedge i_clk) begin : watch
        t_answer want;
        int      k;
        if (!i_rst_n) begin
            for (k = 0; k < TABLE_DEPTH; k++)
                fat_copy[k] = '0;
            size_cfg = CNT_W'(TABLE_DEPTH);
            answer_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                size_cfg = i_cfg_data;
            if (i_rsp_valid && i_rsp_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("response with no request pending", 32'(i_cluster), '0);
                end else begin
                    want = answer_q.pop_front();
                    if (i_cluster !== want.cluster)
                        report_mismatch("cluster", 32'(i_cluster), 32'(want.cluster));
                    if (i_linked !== want.linked)
                        report_mismatch("linked", 32'(i_linked), 32'(want.linked));
                    if (i_error !== want.error)
                        report_mismatch("error", 32'(i_error), 32'(want.error));
                end
            end
            if (i_req_valid && i_req_ready)
                answer_q.push_back(apply_fat_op(t_func'(i_func), i_index, i_value, i_count));
        end
        o_pending <= answer_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the FAT32 cluster chain allocator: clock, reset, request traffic,
// response stalls, table_size phases, watchdog and verdict.
// Depends on fcca_pkg, fat_cluster_chain_allocator and fat_chain_checker.
module tb_top;
    import fcca_pkg::*;

    localparam int STALL_LIMIT = 50000;
    localparam int LONG_HOLD   = 600;
    localparam int FILL_LIMIT  = 256;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_ready;
    logic [1:0]         req_func    = '0;
    logic [IDX_W-1:0]   req_index   = '0;
    logic [ENTRY_W-1:0] req_value   = '0;
    logic [CNT_W-1:0]   req_count   = '0;
    logic               rsp_valid;
    logic               rsp_ready   = 1'b0;
    logic [ENTRY_W-1:0] rsp_cluster;
    logic [CNT_W-1:0]   rsp_linked;
    logic               rsp_error;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data    = '0;

    int   pending;
    int   fail_cnt;
    int   burst_left   = 0;
    int   span_now     = TABLE_DEPTH;
    int   filled_upto  = 0;
    int   quiet_cycles = 0;
    logic hold_pending = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    fat_cluster_chain_allocator i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_ready     (req_ready),
        .i_func      (req_func),
        .i_index     (req_index),
        .i_value     (req_value),
        .i_count     (req_count),
        .o_valid     (rsp_valid),
        .i_ready     (rsp_ready),
        .o_cluster   (rsp_cluster),
        .o_linked    (rsp_linked),
        .o_error     (rsp_error),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    fat_chain_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_func      (req_func),
        .i_index     (req_index),
        .i_value     (req_value),
        .i_count     (req_count),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_cluster   (rsp_cluster),
        .i_linked    (rsp_linked),
        .i_error     (rsp_error),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_fail_cnt  (fail_cnt)
    );

    // Offer one request and hold it until the transaction completes; valid stays
    // high afterwards so that the next request of a burst follows without a gap
    task automatic push_req(input t_func op, input logic [IDX_W-1:0] idx,
                            input logic [ENTRY_W-1:0] val, input logic [CNT_W-1:0] cnt);
        if (burst_left == 0) begin
            if (req_valid) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_func  <= op;
        req_index <= idx;
        req_value <= val;
        req_count <= cnt;
        do @(posedge clk); while (!req_ready);
    endtask

    // Drop valid and wait until every pending answer has come back
    task automatic settle_idle();
        if (req_valid)
            req_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write table_size while idle, then load every newly covered entry as free;
    // wide tables stay unloaded and only see traffic on entries written first
    task automatic set_table_size(input logic [CNT_W-1:0] sz);
        int k;
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        span_now = (sz > TABLE_DEPTH) ? TABLE_DEPTH : int'(sz);
        if (span_now <= FILL_LIMIT) begin
            for (k = filled_upto; k < span_now; k++)
                push_req(FUNC_WRITE, IDX_W'(k), '0, '0);
            if (span_now > filled_upto)
                filled_upto = span_now;
        end
    endtask

    // Random traffic: frees, links and end marks, allocations, walks and reads
    task automatic run_random(input int n);
        int                 k;
        int                 pick;
        int                 sel;
        t_func              op;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] val;
        logic [CNT_W-1:0]   cnt;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            op   = (pick < 25) ? FUNC_WRITE :
                   (pick < 50) ? FUNC_ALLOC :
                   (pick < 80) ? FUNC_WALK  : FUNC_READ;
            // mostly in range, now and then any index at all
            if (span_now == 0 || $urandom_range(0, 9) == 0)
                idx = IDX_W'($urandom);
            else
                idx = IDX_W'($urandom_range(0, span_now - 1));
            sel = $urandom_range(0, 9);
            if (sel < 4)
                val = '0;
            else if (sel < 6)
                val = END_MARK + ENTRY_W'($urandom_range(0, 7));
            else if (sel < 9)
                val = (span_now == 0) ? '0 : ENTRY_W'($urandom_range(0, span_now - 1));
            else
                val = ENTRY_W'($urandom);
            cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom)
                                              : CNT_W'($urandom_range(0, 8));
            push_req(op, idx, val, cnt);
        end
    endtask

    // Top-of-table cases for wide sizes: touch only entries written here
    task automatic run_wide();
        push_req(FUNC_WRITE, 12'd4095, END_MARK, '0);
        push_req(FUNC_READ, 12'd4095, '0, '0);
        push_req(FUNC_WALK, 12'd4095, '0, '0);
        push_req(FUNC_WRITE, 12'd2048, 28'd4095, '0);  // link to the last entry
        push_req(FUNC_WALK, 12'd2048, '0, '0);
        push_req(FUNC_READ, 12'd2048, '0, '0);
    endtask

    // Directed cases on a 16-entry table that starts all free
    task automatic run_directed();
        push_req(FUNC_WRITE, 12'd0, 28'hFFFFFFF, '0);
        push_req(FUNC_READ, 12'd0, '0, '0);
        push_req(FUNC_WALK, 12'd0, '0, '0);           // end mark right at the start
        push_req(FUNC_WRITE, 12'd15, '0, '0);
        push_req(FUNC_WRITE, 12'd4095, 28'h5A5A5A5, '0); // out of range, ignored
        push_req(FUNC_READ, 12'd16, '0, '0);
        push_req(FUNC_WALK, 12'd4095, '0, '0);
        push_req(FUNC_ALLOC, '0, '0, 13'd0);          // zero count
        push_req(FUNC_ALLOC, '0, '0, 13'd3);          // chain 1 -> 2 -> 3
        push_req(FUNC_WALK, 12'd1, '0, '0);
        push_req(FUNC_READ, 12'd2, '0, '0);
        push_req(FUNC_WRITE, 12'd0, '0, '0);          // free cluster 0
        push_req(FUNC_ALLOC, '0, '0, 13'd1);          // hands out cluster 0
        push_req(FUNC_WRITE, 12'd5, 28'd6, '0);       // loop 5 <-> 6
        push_req(FUNC_WRITE, 12'd6, 28'd5, '0);
        push_req(FUNC_WALK, 12'd5, '0, '0);
        push_req(FUNC_WRITE, 12'd7, 28'd20, '0);      // link past the table end
        push_req(FUNC_WALK, 12'd7, '0, '0);
        push_req(FUNC_WRITE, 12'd8, END_MARK, '0);
        push_req(FUNC_WALK, 12'd8, '0, '0);
        push_req(FUNC_WRITE, 12'd9, END_MARK - 28'd1, '0);
        push_req(FUNC_WALK, 12'd9, '0, '0);
        push_req(FUNC_ALLOC, '0, '0, 13'h1FFF);       // take every free entry
        push_req(FUNC_ALLOC, '0, '0, 13'd5);          // nothing left
        push_req(FUNC_WALK, 12'd4, '0, '0);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        set_table_size(13'd16);
        run_directed();
        set_table_size(13'd0);
        run_random(20);
        set_table_size(13'd1);
        run_random(40);
        set_table_size(13'h1FFF);
        run_wide();
        set_table_size(13'd64);
        hold_pending = 1'b1;
        run_random(300);
        set_table_size(13'd4096);
        run_wide();
        set_table_size(13'd200);
        run_random(300);
        set_table_size(13'd33);
        run_random(300);
        set_table_size(13'd4095);
        run_wide();
        set_table_size(13'd100);
        run_random(250);
        settle_idle();
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("PASS fat_cluster_chain_allocator");
        else
            $display("FAIL fat_cluster_chain_allocator");
        $finish;
    end

    // Response side: stall in random modes, plus one long hold-off on request
    initial begin : rsp_side
        int mode;
        int span;
        int k;
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                @(posedge clk);
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            for (k = 0; k < span; k++) begin
                @(posedge clk);
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL fat_cluster_chain_allocator");
            $finish;
        end
    end

endmodule

>>> filelist.f
+incdir+sv
sv/fcca_pkg.sv
sv/fcca_table.sv
sv/fat_cluster_chain_allocator.sv
tb/sv/fat_chain_checker.sv
tb/sv/tb_top.sv
